// ----- src/dac_shadow_refresh_sequencer_core_defines.svh -----
// Assertion macros for the checker file of the DAC shadow refresh sequencer.
`ifndef DAC_SHADOW_REFRESH_SEQUENCER_CORE_DEFINES_SVH
`define DAC_SHADOW_REFRESH_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsrs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsrs check failed");

`endif

// ----- src/dsrs_pkg.sv -----
`timescale 1ns / 1ps
package dsrs_pkg;

	localparam int NUM_CHANNELS = 14;
	localparam int LEVEL_BITS   = 10;
	localparam int IDX_BITS     = $clog2(NUM_CHANNELS);
	localparam int CHAN_BITS    = 4;
	localparam int OP_BITS      = 3;
	localparam int BYTE_BITS    = 8;
	localparam int PCODE_BITS   = 3;
	localparam int PIN_COUNT    = 5;
	localparam int RESET_LEVEL  = 'h100;

	typedef enum logic [OP_BITS-1:0] {
		OP_DAC_DONE = 3'd0,
		OP_START    = 3'd1,
		OP_UPDATE   = 3'd2,
		OP_PORT     = 3'd3,
		OP_MISC     = 3'd4
	} op_t;

	typedef struct packed {
		logic [OP_BITS-1:0]    opcode;
		logic [CHAN_BITS-1:0]  channel;
		logic [LEVEL_BITS-1:0] level;
		logic [BYTE_BITS-1:0]  port_byte;
		logic [PCODE_BITS-1:0] pin_code;
		logic                  pin_level;
	} cmd_t;

	typedef struct packed {
		logic                  dac_write;
		logic [CHAN_BITS-1:0]  dac_channel;
		logic [LEVEL_BITS-1:0] dac_level;
		logic                  port_write;
		logic [BYTE_BITS-1:0]  port_out;
		logic [PIN_COUNT-1:0]  misc_pins;
		logic                  bad_channel;
	} res_t;

	// What the state block shows for the command in stage one.
	typedef struct packed {
		logic [IDX_BITS-1:0]   idx;
		logic [LEVEL_BITS-1:0] level;
		logic [PIN_COUNT-1:0]  pins_nxt;
	} state_view_t;

	function automatic logic chan_ok(input logic [CHAN_BITS-1:0] ch);
		return int'(ch) < NUM_CHANNELS;
	endfunction

endpackage

// ----- src/dsrs_ifs.sv -----
`timescale 1ns / 1ps
interface dsrs_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [dsrs_pkg::OP_BITS-1:0]    opcode;
	logic [dsrs_pkg::CHAN_BITS-1:0]  channel;
	logic [dsrs_pkg::LEVEL_BITS-1:0] level;
	logic [dsrs_pkg::BYTE_BITS-1:0]  port_byte;
	logic [dsrs_pkg::PCODE_BITS-1:0] pin_code;
	logic                                 pin_level;

	modport source (output valid, opcode, channel, level, port_byte, pin_code, pin_level,
		input ready);
	modport sink (input valid, opcode, channel, level, port_byte, pin_code, pin_level,
		output ready);
endinterface

interface dsrs_res_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 dac_write;
	logic [dsrs_pkg::CHAN_BITS-1:0]  dac_channel;
	logic [dsrs_pkg::LEVEL_BITS-1:0] dac_level;
	logic                                 port_write;
	logic [dsrs_pkg::BYTE_BITS-1:0]  port_out;
	logic [dsrs_pkg::PIN_COUNT-1:0]  misc_pins;
	logic                                 bad_channel;

	modport source (output valid, dac_write, dac_channel, dac_level, port_write, port_out,
		misc_pins, bad_channel, input ready);
	modport sink (input valid, dac_write, dac_channel, dac_level, port_write, port_out,
		misc_pins, bad_channel, output ready);
endinterface

// ----- src/dsrs_state.sv -----
`timescale 1ns / 1ps
module dsrs_state (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  dsrs_pkg::cmd_t        cmd,
	output dsrs_pkg::state_view_t view
);

	logic [dsrs_pkg::LEVEL_BITS-1:0] levels_q [dsrs_pkg::NUM_CHANNELS];
	logic [dsrs_pkg::IDX_BITS-1:0]   idx_q;
	logic [dsrs_pkg::PIN_COUNT-1:0]  pins_q;
	logic [dsrs_pkg::IDX_BITS-1:0]   cur_idx;
	logic [dsrs_pkg::IDX_BITS-1:0]   idx_nxt;
	logic [dsrs_pkg::PIN_COUNT-1:0]  pins_nxt;
	logic [dsrs_pkg::IDX_BITS-1:0]   upd_idx;
	logic                            upd_ok;
	dsrs_pkg::op_t                   op;

	assign op      = dsrs_pkg::op_t'(cmd.opcode);
	// An index beyond the table cannot arise from reset, but reads as channel zero.
	assign cur_idx = (int'(idx_q) < dsrs_pkg::NUM_CHANNELS) ? idx_q : '0;
	assign upd_ok  = dsrs_pkg::chan_ok(cmd.channel);
	assign upd_idx = cmd.channel[dsrs_pkg::IDX_BITS-1:0];

	always_comb begin
		idx_nxt  = idx_q;
		pins_nxt = pins_q;
		unique case (op)
			dsrs_pkg::OP_DAC_DONE, dsrs_pkg::OP_START: begin
				if (int'(cur_idx) == dsrs_pkg::NUM_CHANNELS - 1) begin
					idx_nxt = '0;
				end else begin
					idx_nxt = cur_idx + 1'b1;
				end
			end
			dsrs_pkg::OP_UPDATE: begin
				if (upd_ok) begin
					idx_nxt = upd_idx;
				end
			end
			dsrs_pkg::OP_MISC: begin
				if (int'(cmd.pin_code) < dsrs_pkg::PIN_COUNT) begin
					pins_nxt[cmd.pin_code] = cmd.pin_level;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pins_q <= '0;
			for (int k = 0; k < dsrs_pkg::NUM_CHANNELS; k++) begin
				levels_q[k] <= dsrs_pkg::LEVEL_BITS'(dsrs_pkg::RESET_LEVEL);
			end
		end else if (fire) begin
			idx_q  <= idx_nxt;
			pins_q <= pins_nxt;
			if (op == dsrs_pkg::OP_UPDATE && upd_ok) begin
				levels_q[upd_idx] <= cmd.level;
			end
		end
	end

	assign view.idx      = cur_idx;
	assign view.level    = levels_q[cur_idx];
	assign view.pins_nxt = pins_nxt;

endmodule

// ----- src/dac_shadow_refresh_sequencer_core.sv -----
`timescale 1ns / 1ps
// Channel | Role   | Payload
// cmd     | sink   | opcode, channel, level, port_byte, pin_code, pin_level
// res     | source | dac_write, dac_channel, dac_level, port_write, port_out,
//         |        | misc_pins, bad_channel
//
// Every transaction on cmd gives exactly one transaction on res. One transaction is taken
// each cycle while res does not stall: a stage-one register holds the command and the
// result register is loaded from it through the shadow table read and decode.
// Reset puts all shadow levels at 0x100 and clears the refresh index and pin latch.
// A stall on res holds the result register and stage one, after which cmd.ready drops.
module dac_shadow_refresh_sequencer_core (
	input logic           clk,
	input logic           arst_n,
	dsrs_cmd_if.sink      cmd,
	dsrs_res_if.source    res
);

	logic                  v_s1;
	dsrs_pkg::cmd_t        cmd_s1;
	logic                  v_s2;
	dsrs_pkg::res_t        res_s2;
	logic                  advance;
	logic                  take;
	dsrs_pkg::state_view_t view;
	dsrs_pkg::res_t        res_d;

	assign advance   = v_s1 && (!v_s2 || res.ready);
	assign cmd.ready = !v_s1 || advance;
	assign take      = cmd.valid && cmd.ready;

	dsrs_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd_s1),
		.view   (view)
	);

	always_comb begin
		res_d           = '0;
		res_d.misc_pins = view.pins_nxt;
		unique case (dsrs_pkg::op_t'(cmd_s1.opcode))
			dsrs_pkg::OP_DAC_DONE, dsrs_pkg::OP_START: begin
				res_d.dac_write   = 1'b1;
				res_d.dac_channel = dsrs_pkg::CHAN_BITS'(view.idx);
				res_d.dac_level   = view.level;
			end
			dsrs_pkg::OP_UPDATE: begin
				res_d.bad_channel = !dsrs_pkg::chan_ok(cmd_s1.channel);
			end
			dsrs_pkg::OP_PORT: begin
				res_d.port_write = 1'b1;
				res_d.port_out   = cmd_s1.port_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (res.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.opcode    <= cmd.opcode;
			cmd_s1.channel   <= cmd.channel;
			cmd_s1.level     <= cmd.level;
			cmd_s1.port_byte <= cmd.port_byte;
			cmd_s1.pin_code  <= cmd.pin_code;
			cmd_s1.pin_level <= cmd.pin_level;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign res.valid       = v_s2;
	assign res.dac_write   = res_s2.dac_write;
	assign res.dac_channel = res_s2.dac_channel;
	assign res.dac_level   = res_s2.dac_level;
	assign res.port_write  = res_s2.port_write;
	assign res.port_out    = res_s2.port_out;
	assign res.misc_pins   = res_s2.misc_pins;
	assign res.bad_channel = res_s2.bad_channel;

endmodule

// ----- src/dsrs_checker.sv -----
`timescale 1ns / 1ps
`include "dac_shadow_refresh_sequencer_core_defines.svh"
module dsrs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic                            dac_write,
	input logic [dsrs_pkg::CHAN_BITS-1:0]  dac_channel,
	input logic [dsrs_pkg::LEVEL_BITS-1:0] dac_level,
	input logic                            port_write,
	input logic [dsrs_pkg::BYTE_BITS-1:0]  port_out,
	input logic                            bad_channel
);

	// A result reports at most one kind of event.
	`DSRS_ASSERT_NOW(a_one_event, clk, arst_n, res_valid,
		$onehot0({dac_write, port_write, bad_channel}))
	// Refreshed channels always lie inside the shadow table.
	`DSRS_ASSERT_NOW(a_chan_range, clk, arst_n, res_valid && dac_write,
		int'(dac_channel) < dsrs_pkg::NUM_CHANNELS)
	// Fields of an event that did not happen read as zero.
	`DSRS_ASSERT_NOW(a_idle_fields, clk, arst_n, res_valid && !dac_write && !port_write,
		dac_channel == '0 && dac_level == '0 && port_out == '0)
	// A stalled result stays offered.
	`DSRS_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid)

endmodule

bind dac_shadow_refresh_sequencer_core dsrs_checker u_dsrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.dac_write   (res.dac_write),
	.dac_channel (res.dac_channel),
	.dac_level   (res.dac_level),
	.port_write  (res.port_write),
	.port_out    (res.port_out),
	.bad_channel (res.bad_channel)
);
